// ===== rtl/dhkt_pkg.sv =====
// Shared types and constants for the double-hashed keyed record table.
// No dependencies; imported by the top level.
package dhkt_pkg;

  localparam int KEY_W       = 27;   // folded eight-digit key, below 10^8
  localparam int RAW_W       = 18;   // widest unreduced hash value
  localparam int HOME_SHIFT  = 12;
  localparam int STEP_SHIFT  = 16;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 48;

  // request kinds
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_KEY   = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef struct packed {
    logic             used;
    logic             dead;
    logic [KEY_W-1:0] key;
  } slot_tag_t;

  localparam int TAG_W = $bits(slot_tag_t);

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== rtl/dhkt_slot_ram.sv =====
// Single-port-write, registered-read slot memory.
// No dependencies; holds slot tag and record word side by side.
module dhkt_slot_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 61
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/double_hash_keyed_table.sv =====
// Keyed record table, open addressing with double hashing (top level).
// Sequence: fold the key digits, hash, reduce modulo CAPACITY when it is not a power of two,
//   then probe; a malformed key goes straight to the result, clear sweeps every slot.
// Throughput: one request at a time; next input transfer in the cycle after the result is
//   loaded. Each slot is read, then evaluated (one read port, registered read data).
// Reset: synchronous; a clearing pass over all CAPACITY slots runs before the first input.
module double_hash_keyed_table #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] head_chars, [23:16] sep_char, [71:24] tail_chars, [103:72] data_in
  input  logic [dhkt_pkg::IN_TDATA_W-1:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] data_out, [40:32] live_count, [47:41] zero
  output logic [dhkt_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic [1:0]                      m_tuser
);

  import dhkt_pkg::*;

  localparam int  AW   = $clog2(CAPACITY);       // slot index
  localparam int  RW   = AW + 1;                 // reducer input, below 2*CAPACITY
  localparam int  CW   = $clog2(CAPACITY + 1);   // live count
  localparam int  SW   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;  // stored word
  localparam int  EW   = TAG_W + SW;
  localparam bit  POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [AW-1:0] LAST_PROBE = AW'(CAPACITY - 1);
  // x mod CAPACITY by reciprocal: q = (x * RECIP) >> RS is exact for x < 2^RAW_W
  localparam int  RS   = RAW_W + AW;
  localparam int  PW   = 2 * RAW_W + 2;
  localparam logic [RAW_W+1:0] RECIP =
    (RAW_W+2)'(((64'd1 << RS) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY));

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FOLD   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_PRB_RD = 3'd4;
  localparam logic [2:0] S_PRB_EV = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;
  localparam logic [2:0] S_CLR    = 3'd7;

  logic [2:0]       state;
  logic [1:0]       op;
  logic [63:0]      chars;       // key digits, next one in the top byte
  logic [SW-1:0]    word_in;
  logic [KEY_W-1:0] key;
  logic [2:0]       dig_cnt;
  logic [RAW_W-1:0] step_raw;
  logic [RAW_W-1:0] mod_src;
  logic             mod_sub;     // 0 reciprocal multiply, 1 subtract
  logic             mod_phase;   // 0 reducing home, 1 reducing step
  logic [RAW_W-1:0] quot;
  logic [AW-1:0]    idx;         // probe slot, also clear sweep address
  logic [AW-1:0]    step;
  logic [AW-1:0]    n;           // probes done
  logic             have_free;
  logic [AW-1:0]    free_idx;
  logic [1:0]       res_status;
  logic [SW-1:0]    res_word;
  logic             clr_reply;   // clear sweep owes a result (not after reset)
  logic [CW-1:0]    live_total;
  logic [1:0]       out_status;
  logic [31:0]      out_word;
  logic [8:0]       out_count;

  // ---------------- input side: key check, hashing
  logic [63:0]      in_chars;
  logic             key_ok;
  logic [KEY_W-1:0] key_next;
  logic [RAW_W-1:0] home_sum, step_sum, home_raw, step_raw_next;

  assign in_chars = {s_tdata[15:0], s_tdata[71:24]};

  always_comb begin
    key_ok = (s_tdata[23:16] == CHAR_HYPHEN);
    for (int i = 0; i < 8; i++) begin
      key_ok = key_ok && is_digit(in_chars[8*i +: 8]);
    end
  end

  // acc*10 + digit; a checked digit's value is its low nibble
  assign key_next = (key << 3) + (key << 1) + KEY_W'(chars[59:56]);

  // home = (hi + lo)*2 + 1, step likewise; sums fit 17 bits
  assign home_sum      = RAW_W'(key >> HOME_SHIFT) + RAW_W'(key[HOME_SHIFT-1:0]);
  assign step_sum      = RAW_W'(key >> STEP_SHIFT) + RAW_W'(key[STEP_SHIFT-1:0]);
  assign home_raw      = {home_sum[RAW_W-2:0], 1'b1};
  assign step_raw_next = {step_sum[RAW_W-2:0], 1'b1};

  // ---------------- hash reduction when CAPACITY is not a power of two
  logic [PW-1:0]    prod;
  logic [RAW_W-1:0] mod_rem;

  assign prod    = PW'(mod_src) * PW'(RECIP);
  assign mod_rem = mod_src - RAW_W'(quot * RAW_W'(CAPACITY));

  // ---------------- probe step: (idx + step) mod CAPACITY
  logic [RW-1:0] red_in, red_out;

  always_comb begin
    red_in  = {1'b0, idx} + {1'b0, step};
    red_out = (red_in >= RW'(CAPACITY)) ? red_in - RW'(CAPACITY) : red_in;
  end

  // ---------------- slot memory
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_tag_t     wr_tag;
  logic [SW-1:0] wr_word;
  logic [EW-1:0] rd_data;
  slot_tag_t     rd_tag;
  logic [SW-1:0] rd_word;

  assign rd_tag  = slot_tag_t'(rd_data[EW-1:SW]);
  assign rd_word = rd_data[SW-1:0];

  dhkt_slot_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({wr_tag, wr_word}),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // probe evaluation on the registered slot read
  logic          hit, end_miss, cand_ok;
  logic [AW-1:0] cand;

  assign hit      = rd_tag.used && !rd_tag.dead && (rd_tag.key == key);
  assign end_miss = !rd_tag.used || (n == LAST_PROBE);
  assign cand_ok  = have_free || !rd_tag.used || rd_tag.dead;
  assign cand     = have_free ? free_idx : idx;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_tag  = '0;
    wr_word = rd_word;
    if (state == S_CLR) begin
      wr_en   = 1'b1;
      wr_word = '0;
    end else if (state == S_PRB_EV) begin
      if (hit) begin
        if (op == OP_REMOVE) begin
          wr_en  = 1'b1;
          wr_tag = '{used: 1'b1, dead: 1'b1, key: key};   // tombstone
        end else if (op == OP_INSERT) begin
          wr_en   = 1'b1;
          wr_tag  = '{used: 1'b1, dead: 1'b0, key: key};
          wr_word = word_in;
        end
      end else if (end_miss && op == OP_INSERT && cand_ok) begin
        wr_en   = 1'b1;
        wr_addr = cand;
        wr_tag  = '{used: 1'b1, dead: 1'b0, key: key};
        wr_word = word_in;
      end
    end
  end

  // ---------------- sequencer
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      idx        <= '0;
      clr_reply  <= 1'b0;
      live_total <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // S_DONE owns m_tvalid while it loads a new result
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= s_tuser;
            chars     <= in_chars;
            word_in   <= s_tdata[72 +: SW];
            key       <= '0;
            dig_cnt   <= '0;
            res_word  <= '0;
            if (s_tuser == OP_CLEAR) begin
              res_status <= STAT_OK;
              live_total <= '0;
              idx        <= '0;
              clr_reply  <= 1'b1;
              state      <= S_CLR;
            end else if (!key_ok) begin
              res_status <= STAT_BAD_KEY;
              state      <= S_DONE;
            end else begin
              state <= S_FOLD;
            end
          end
        end
        S_FOLD: begin
          key     <= key_next;
          chars   <= chars << 8;
          dig_cnt <= dig_cnt + 3'd1;
          if (dig_cnt == 3'd7) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          n         <= '0;
          have_free <= 1'b0;
          if (POW2) begin
            idx   <= home_raw[AW-1:0];
            step  <= step_raw_next[AW-1:0];
            state <= S_PRB_RD;
          end else begin
            step_raw  <= step_raw_next;
            mod_src   <= home_raw;
            mod_sub   <= 1'b0;
            mod_phase <= 1'b0;
            state     <= S_MOD;
          end
        end
        S_MOD: begin
          // each value: quotient first, then remainder
          mod_sub <= !mod_sub;
          if (!mod_sub) begin
            quot <= RAW_W'(prod >> RS);
          end else if (!mod_phase) begin
            idx       <= mod_rem[AW-1:0];
            mod_src   <= step_raw;
            mod_phase <= 1'b1;
          end else begin
            step  <= mod_rem[AW-1:0];
            state <= S_PRB_RD;
          end
        end
        S_PRB_RD: begin
          state <= S_PRB_EV;   // read data lands next cycle
        end
        S_PRB_EV: begin
          if (hit) begin
            res_status <= STAT_OK;
            if (op == OP_INSERT) begin
              res_word <= word_in;
            end else begin
              res_word <= rd_word;
            end
            if (op == OP_REMOVE && live_total != '0) begin
              live_total <= live_total - CW'(1);
            end
            state <= S_DONE;
          end else if (end_miss) begin
            if (op != OP_INSERT) begin
              res_status <= STAT_NOT_FOUND;
            end else if (cand_ok) begin
              res_status <= STAT_OK;
              res_word   <= word_in;
              live_total <= live_total + CW'(1);
            end else begin
              res_status <= STAT_FULL;
            end
            state <= S_DONE;
          end else begin
            if (rd_tag.dead && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= idx;
            end
            n     <= n + AW'(1);
            idx   <= red_out[AW-1:0];
            state <= S_PRB_RD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_word   <= 32'(res_word);
            out_count  <= 9'(live_total);
            state      <= S_IDLE;
          end
        end
        S_CLR: begin
          idx <= idx + AW'(1);
          if (idx == LAST_PROBE) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'd0, out_count, out_word};
  assign m_tuser = out_status;

endmodule
